// ===== hdl/assert_macros.svh =====
// assertion macros shared by the deframer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/adts_pkg.sv =====
// shared types, constants and the rate table of the adts deframer
`timescale 1ns / 1ps

package adts_pkg;

  localparam int WIN_LEN       = 6;
  localparam int HDR_LEN_PLAIN = 7;
  localparam int HDR_LEN_CRC   = 9;

  localparam logic [7:0] SYNC_BYTE  = 8'hFF;
  localparam logic [7:0] SYNC_MASK  = 8'hF6;
  localparam logic [7:0] SYNC_VALUE = 8'hF0;

  // header bytes left to skip once the window has matched
  localparam logic [1:0] SKIP_PLAIN = 2'(HDR_LEN_PLAIN - WIN_LEN);
  localparam logic [1:0] SKIP_CRC   = 2'(HDR_LEN_CRC - WIN_LEN);

  // commands from the controller, valid only in a cycle that takes a request
  typedef struct packed {
    logic win_shift;
    logic hdr_load;
    logic br_dec;
    logic frame_done;
    logic emit;
    logic emit_first;
    logic emit_last;
  } cmd_t;

  // status from the datapath
  typedef struct packed {
    logic out_busy;
    logic hdr_ok;
    logic hdr_crc;
    logic br_last;
  } status_t;

  // base sampling rate for a frequency index, zero for reserved codes
  function automatic logic [16:0] rate_hz(input logic [3:0] idx);
    logic [16:0] r;
    case (idx)
      4'd0:    r = 17'd96000;
      4'd1:    r = 17'd88200;
      4'd2:    r = 17'd64000;
      4'd3:    r = 17'd48000;
      4'd4:    r = 17'd44100;
      4'd5:    r = 17'd32000;
      4'd6:    r = 17'd24000;
      4'd7:    r = 17'd22050;
      4'd8:    r = 17'd16000;
      4'd9:    r = 17'd12000;
      4'd10:   r = 17'd11025;
      4'd11:   r = 17'd8000;
      4'd12:   r = 17'd7350;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/adts_datapath.sv =====
// deframer datapath: sync window, header decode, counters and output register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adts_datapath import adts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  data_byte,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [7:0]  out_payload_byte,
  output logic        out_first_of_frame,
  output logic        out_last_of_frame,
  output logic [2:0]  out_object_type,
  output logic [3:0]  out_rate_index,
  output logic [16:0] out_sample_rate_hz,
  output logic [2:0]  out_channel_config,
  output logic        out_crc_present,
  output logic [31:0] out_frame_number
);

  localparam logic [2:0] FILL_FULL = 3'(WIN_LEN - 1);

  // five stored bytes, oldest first; the incoming byte completes the window
  logic [7:0]  win_r [0:WIN_LEN-2];
  logic [2:0]  fill_r, fill_nxt;
  logic [12:0] br_r, br_nxt;
  logic [1:0]  prof_r;
  logic [3:0]  ridx_r;
  logic [2:0]  chan_r;
  logic        crc_r;
  logic [31:0] fcnt_r;
  logic        out_valid_r, out_valid_nxt;

  logic [7:0]  cand [0:WIN_LEN-1];
  logic        crc_flag;
  logic [12:0] flen;
  logic [12:0] hlen;

  // candidate header window
  always_comb begin
    for (int i = 0; i < WIN_LEN - 1; i++) begin
      cand[i] = win_r[i];
    end
    cand[WIN_LEN-1] = data_byte;
  end

  // header decode on the full window
  assign crc_flag = ~cand[1][0];
  assign flen     = {cand[3][1:0], cand[4], cand[5][7:5]};
  assign hlen     = crc_flag ? 13'(HDR_LEN_CRC) : 13'(HDR_LEN_PLAIN);

  assign status.out_busy = out_valid_r & out_stall;
  assign status.hdr_ok   = (fill_r == FILL_FULL) && (cand[0] == SYNC_BYTE) &&
                           ((cand[1] & SYNC_MASK) == SYNC_VALUE) && (flen >= hlen);
  assign status.hdr_crc  = crc_flag;
  assign status.br_last  = (br_r <= 13'd1);

  // window fill and remaining byte count
  always_comb begin
    fill_nxt = fill_r;
    br_nxt   = br_r;
    if (cmd.frame_done || cmd.hdr_load) begin
      fill_nxt = 3'd0;
    end else if (cmd.win_shift && fill_r != FILL_FULL) begin
      fill_nxt = fill_r + 3'd1;
    end
    if (cmd.frame_done) begin
      br_nxt = 13'd0;
    end else if (cmd.hdr_load) begin
      br_nxt = flen - 13'(WIN_LEN);
    end else if (cmd.br_dec && br_r != 13'd0) begin
      br_nxt = br_r - 13'd1;
    end
  end

  // output register valid
  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= 3'd0;
      br_r        <= 13'd0;
      prof_r      <= 2'd0;
      ridx_r      <= 4'd0;
      chan_r      <= 3'd0;
      crc_r       <= 1'b0;
      fcnt_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      br_r        <= br_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.hdr_load) begin
        prof_r <= cand[2][7:6];
        ridx_r <= cand[2][5:2];
        chan_r <= {cand[2][0], cand[3][7:6]};
        crc_r  <= crc_flag;
      end
      if (cmd.frame_done) begin
        fcnt_r <= fcnt_r + 32'd1;
      end
    end
  end

  // window shift and result payload
  always_ff @(posedge clk) begin
    if (cmd.win_shift) begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        win_r[i] <= cand[i+1];
      end
    end
    if (cmd.emit) begin
      out_payload_byte   <= data_byte;
      out_first_of_frame <= cmd.emit_first;
      out_last_of_frame  <= cmd.emit_last;
      out_object_type    <= {1'b0, prof_r} + 3'd1;
      out_rate_index     <= ridx_r;
      out_sample_rate_hz <= rate_hz(ridx_r);
      out_channel_config <= chan_r;
      out_crc_present    <= crc_r;
      out_frame_number   <= fcnt_r;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_IMPL(a_emit_not_busy, cmd.emit, !status.out_busy)
  `ASSERT_NEXT(a_done_clears, cmd.frame_done, fill_r == 3'd0 && br_r == 13'd0)
  `ASSERT_IMPL(a_rose_after_emit, $rose(out_valid_r), $past(cmd.emit))
  `ASSERT_ALWAYS(a_fill_range, fill_r <= FILL_FULL)

endmodule

// ===== hdl/adts_ctrl.sv =====
// deframer controller: hunt, header skip and payload state machine
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adts_ctrl import adts_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_HUNT    = 2'd0,
    S_SKIP    = 2'd1,
    S_PAYLOAD = 2'd2
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] skip_cnt_r, skip_cnt_nxt;
  logic       first_pending_r, first_pending_nxt;
  logic       accept;

  assign accept = in_valid & ~status.out_busy;

  // next state and commands
  always_comb begin
    state_nxt         = state_r;
    skip_cnt_nxt      = skip_cnt_r;
    first_pending_nxt = first_pending_r;
    cmd               = '0;
    if (accept) begin
      unique case (state_r)
        S_HUNT: begin
          cmd.win_shift = 1'b1;
          if (status.hdr_ok) begin
            cmd.hdr_load      = 1'b1;
            skip_cnt_nxt      = status.hdr_crc ? SKIP_CRC : SKIP_PLAIN;
            first_pending_nxt = 1'b1;
            state_nxt         = S_SKIP;
          end
        end
        S_SKIP: begin
          cmd.br_dec = 1'b1;
          if (skip_cnt_r != 2'd0) begin
            skip_cnt_nxt = skip_cnt_r - 2'd1;
          end
          if (skip_cnt_r <= 2'd1) begin
            if (status.br_last) begin
              cmd.frame_done = 1'b1;
              state_nxt      = S_HUNT;
            end else begin
              state_nxt = S_PAYLOAD;
            end
          end
        end
        S_PAYLOAD: begin
          cmd.br_dec        = 1'b1;
          cmd.emit          = 1'b1;
          cmd.emit_first    = first_pending_r;
          cmd.emit_last     = status.br_last;
          first_pending_nxt = 1'b0;
          if (status.br_last) begin
            cmd.frame_done = 1'b1;
            state_nxt      = S_HUNT;
          end
        end
        default: begin
          state_nxt = S_HUNT;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_HUNT;
      skip_cnt_r      <= 2'd0;
      first_pending_r <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      skip_cnt_r      <= skip_cnt_nxt;
      first_pending_r <= first_pending_nxt;
    end
  end

  `ASSERT_IMPL(a_skip_nonzero, state_r == S_SKIP, skip_cnt_r != 2'd0)
  `ASSERT_NEXT(a_load_to_skip, cmd.hdr_load, state_r == S_SKIP && first_pending_r)
  `ASSERT_IMPL(a_done_from_frame, cmd.frame_done, state_r == S_SKIP || state_r == S_PAYLOAD)

endmodule

// ===== hdl/adts_frame_deframer.sv =====
// top level of the adts byte-stream deframer
`timescale 1ns / 1ps

// ADTS deframer: takes one stream byte per request and hunts for a header
// (sync 0xFFF, layer 00, frame length at least the header length) over a
// six-byte window, skipping one byte on a mismatch. After the header and
// any CRC bytes it delivers each payload byte as one result request with
// first/last marks, the header fields, the table sample rate and the count
// of frames finished before it. A new byte is taken in every cycle
// while in_stall is low; the single output register holds a result
// until it is taken, and in_stall is high only while that register is full
// and out_stall is high. Header and CRC bytes produce no result. No
// clearing pass follows reset.
module adts_frame_deframer import adts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_payload_byte,
  output logic        out_first_of_frame,
  output logic        out_last_of_frame,
  output logic [2:0]  out_object_type,
  output logic [3:0]  out_rate_index,
  output logic [16:0] out_sample_rate_hz,
  output logic [2:0]  out_channel_config,
  output logic        out_crc_present,
  output logic [31:0] out_frame_number
);

  cmd_t    cmd;
  status_t status;

  assign in_stall = status.out_busy;

  // sequencing
  adts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd)
  );

  // window, decode and result register
  adts_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .data_byte          (in_data_byte),
    .cmd                (cmd),
    .status             (status),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_payload_byte   (out_payload_byte),
    .out_first_of_frame (out_first_of_frame),
    .out_last_of_frame  (out_last_of_frame),
    .out_object_type    (out_object_type),
    .out_rate_index     (out_rate_index),
    .out_sample_rate_hz (out_sample_rate_hz),
    .out_channel_config (out_channel_config),
    .out_crc_present    (out_crc_present),
    .out_frame_number   (out_frame_number)
  );

endmodule

// ===== test/adts_frame_deframer_tb.sv =====
// self-checking testbench for the adts byte-stream deframer
`timescale 1ns / 1ps

module adts_frame_deframer_tb;
  import adts_pkg::*;

  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned IDLE_LIMIT      = 4000;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned RANDOM_BYTES    = 200;
  localparam int unsigned LONG_PAYLOAD    = 249;

  // one payload byte as the block reports it
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        first_of_frame;
    logic        last_of_frame;
    logic [2:0]  object_type;
    logic [3:0]  rate_index;
    logic [16:0] sample_rate_hz;
    logic [2:0]  channel_config;
    logic        crc_present;
    logic [31:0] frame_number;
  } au_byte_t;

  typedef enum logic [1:0] {SCAN_SYNC, SKIP_HEADER, PASS_PAYLOAD} deframe_phase_t;
  typedef enum int {FAULT_NONE, FAULT_SYNC_WORD, FAULT_LAYER, FAULT_LENGTH} header_fault_t;
  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_HEAVY, STALL_SPARSE} stall_pattern_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_payload_byte;
  logic        out_first_of_frame;
  logic        out_last_of_frame;
  logic [2:0]  out_object_type;
  logic [3:0]  out_rate_index;
  logic [16:0] out_sample_rate_hz;
  logic [2:0]  out_channel_config;
  logic        out_crc_present;
  logic [31:0] out_frame_number;

  // deframer state mirrored by the predictor
  deframe_phase_t scan_phase;
  logic [7:0]     scan_win [0:5];
  int unsigned    win_fill;
  int unsigned    skip_left;
  logic [12:0]    bytes_left;
  logic [1:0]     hdr_profile;
  logic [3:0]     hdr_rate_index;
  logic [2:0]     hdr_channels;
  logic           hdr_crc;
  logic [31:0]    frames_done;
  logic           first_pending;
  logic [16:0]    rate_by_index [0:15];

  au_byte_t    expected_payload_q [$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  logic        hold_start = 1'b0;

  adts_frame_deframer u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_payload_byte   (out_payload_byte),
    .out_first_of_frame (out_first_of_frame),
    .out_last_of_frame  (out_last_of_frame),
    .out_object_type    (out_object_type),
    .out_rate_index     (out_rate_index),
    .out_sample_rate_hz (out_sample_rate_hz),
    .out_channel_config (out_channel_config),
    .out_crc_present    (out_crc_present),
    .out_frame_number   (out_frame_number)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state after reset
  function automatic void reset_predictor();
    scan_phase     = SCAN_SYNC;
    win_fill       = 0;
    skip_left      = 0;
    bytes_left     = '0;
    hdr_profile    = '0;
    hdr_rate_index = '0;
    hdr_channels   = '0;
    hdr_crc        = 1'b0;
    frames_done    = '0;
    first_pending  = 1'b0;
    for (int i = 0; i < WIN_LEN; i++) scan_win[i] = '0;
    rate_by_index = '{17'd96000, 17'd88200, 17'd64000, 17'd48000, 17'd44100, 17'd32000,
                      17'd24000, 17'd22050, 17'd16000, 17'd12000, 17'd11025, 17'd8000,
                      17'd7350, 17'd0, 17'd0, 17'd0};
  endfunction

  function automatic void close_frame();
    frames_done = frames_done + 32'd1;
    scan_phase  = SCAN_SYNC;
    win_fill    = 0;
    bytes_left  = '0;
  endfunction

  // advance the predictor by one accepted stream byte
  function automatic void deframe_byte(input logic [7:0] b);
    au_byte_t    rec;
    logic        crc;
    logic [12:0] flen;
    int unsigned hlen;
    case (scan_phase)
      SKIP_HEADER: begin
        if (bytes_left != 0) bytes_left = bytes_left - 13'd1;
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) begin
          if (bytes_left == 0) close_frame();
          else scan_phase = PASS_PAYLOAD;
        end
      end
      PASS_PAYLOAD: begin
        if (bytes_left != 0) bytes_left = bytes_left - 13'd1;
        rec.payload_byte   = b;
        rec.first_of_frame = first_pending;
        rec.last_of_frame  = (bytes_left == 0);
        rec.object_type    = {1'b0, hdr_profile} + 3'd1;
        rec.rate_index     = hdr_rate_index;
        rec.sample_rate_hz = rate_by_index[hdr_rate_index];
        rec.channel_config = hdr_channels;
        rec.crc_present    = hdr_crc;
        rec.frame_number   = frames_done;
        expected_payload_q.push_back(rec);
        first_pending = 1'b0;
        if (rec.last_of_frame) close_frame();
      end
      default: begin
        scan_win[win_fill] = b;
        win_fill++;
        if (win_fill == WIN_LEN) begin
          crc  = ~scan_win[1][0];
          hlen = crc ? HDR_LEN_CRC : HDR_LEN_PLAIN;
          flen = {scan_win[3][1:0], scan_win[4], scan_win[5][7:5]};
          if (scan_win[0] != SYNC_BYTE || (scan_win[1] & SYNC_MASK) != SYNC_VALUE ||
              flen < hlen) begin
            // drop the oldest byte and keep hunting
            for (int i = 0; i < WIN_LEN - 1; i++) scan_win[i] = scan_win[i + 1];
            win_fill = WIN_LEN - 1;
          end else begin
            hdr_profile    = scan_win[2][7:6];
            hdr_rate_index = scan_win[2][5:2];
            hdr_channels   = {scan_win[2][0], scan_win[3][7:6]};
            hdr_crc        = crc;
            bytes_left     = 13'(flen - WIN_LEN);
            skip_left      = hlen - WIN_LEN;
            first_pending  = 1'b1;
            scan_phase     = SKIP_HEADER;
          end
        end
      end
    endcase
  endfunction

  // offer one byte in a burst, wait for the request to be taken
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    deframe_byte(b);
  endtask

  task automatic send_random_bytes(input int unsigned n);
    repeat (n) send_byte(8'($urandom));
  endtask

  // junk between frames, rich in sync bytes
  task automatic send_noise(input int unsigned n);
    repeat (n) send_byte(($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom));
  endtask

  // header with random don't-care bits, optionally broken
  task automatic send_header(input logic [1:0] profile, input logic [3:0] rate_idx,
                             input logic [2:0] channels, input logic crc,
                             input logic [12:0] flen, input header_fault_t fault);
    logic [7:0]  hdr [0:8];
    logic [31:0] r;
    int unsigned hdr_len;
    r       = $urandom;
    hdr_len = crc ? HDR_LEN_CRC : HDR_LEN_PLAIN;
    hdr[0]  = SYNC_BYTE;
    hdr[1]  = {4'hF, r[0], 2'b00, ~crc};
    hdr[2]  = {profile, rate_idx, r[1], channels[2]};
    hdr[3]  = {channels[1:0], r[5:2], flen[12:11]};
    hdr[4]  = flen[10:3];
    hdr[5]  = {flen[2:0], r[10:6]};
    hdr[6]  = r[18:11];
    hdr[7]  = 8'($urandom);
    hdr[8]  = 8'($urandom);
    if (fault == FAULT_SYNC_WORD) hdr[0] = 8'($urandom_range(0, 254));
    if (fault == FAULT_LAYER) hdr[1][2:1] = 2'($urandom_range(1, 3));
    for (int i = 0; i < hdr_len; i++) send_byte(hdr[i]);
  endtask

  task automatic send_frame(input logic [1:0] profile, input logic [3:0] rate_idx,
                            input logic [2:0] channels, input logic crc,
                            input int unsigned payload_len);
    int unsigned hdr_len;
    hdr_len = crc ? HDR_LEN_CRC : HDR_LEN_PLAIN;
    send_header(profile, rate_idx, channels, crc, 13'(hdr_len + payload_len), FAULT_NONE);
    send_random_bytes(payload_len);
  endtask

  // mostly short frames, some empty, a few long
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 19);
    if (pick == 0) len = 0;
    else if (pick == 1) len = $urandom_range(40, 160);
    else len = $urandom_range(1, 12);
    send_frame(2'($urandom), 4'($urandom), 3'($urandom), 1'($urandom), len);
  endtask

  // a header that must be rejected, then some junk
  task automatic send_broken_header(input header_fault_t fault);
    logic        crc;
    int unsigned hdr_len;
    logic [12:0] flen;
    crc     = 1'($urandom);
    hdr_len = crc ? HDR_LEN_CRC : HDR_LEN_PLAIN;
    if (fault == FAULT_LENGTH) flen = 13'($urandom_range(0, hdr_len - 1));
    else flen = 13'($urandom_range(hdr_len, hdr_len + 20));
    send_header(2'($urandom), 4'($urandom), 3'($urandom), crc, flen, fault);
    send_noise($urandom_range(0, 4));
  endtask

  // sender goes quiet until every expected byte is out
  task automatic wait_results_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_payload_q.size() != 0) @(posedge clk);
  endtask

  // extreme header fields, one-byte payloads, empty crc frame
  task automatic test_header_fields();
    send_header(2'd3, 4'd12, 3'd7, 1'b0, 13'(HDR_LEN_PLAIN + 1), FAULT_NONE);
    send_byte(8'hFF);
    send_frame(2'd0, 4'd15, 3'd0, 1'b1, 0);
    send_header(2'd0, 4'd0, 3'd1, 1'b0, 13'(HDR_LEN_PLAIN + 1), FAULT_NONE);
    send_byte(8'h00);
    wait_results_drained();
  endtask

  // every kind of rejected header, then random ones, each before a good frame
  task automatic test_sync_recovery();
    header_fault_t fault;
    for (int i = 0; i < 12; i++) begin
      if (i < 3) fault = header_fault_t'(i + 1);
      else fault = header_fault_t'($urandom_range(1, 3));
      send_broken_header(fault);
      send_random_frame();
    end
    wait_results_drained();
  endtask

  // mostly clean frames mixed with junk and broken headers
  task automatic test_random_stream();
    int unsigned stop_at;
    int unsigned pick;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) send_random_frame();
      else if (pick < 85) send_noise($urandom_range(1, 6));
      else send_broken_header(header_fault_t'($urandom_range(1, 3)));
    end
    wait_results_drained();
  endtask

  // receiver holds off while frames keep coming, so the input stalls
  task automatic test_output_holdoff();
    hold_start = 1'b1;
    send_frame(2'($urandom), 4'($urandom), 3'($urandom), 1'($urandom), 20);
    repeat (4) send_random_frame();
    wait_results_drained();
  endtask

  // long frame past one byte of length, then a short frame to check the counter
  task automatic test_longest_frame();
    send_frame(2'd2, 4'd3, 3'd2, 1'b0, LONG_PAYLOAD);
    send_frame(2'd1, 4'd13, 3'd6, 1'b1, 3);
    wait_results_drained();
  endtask

  // report one field that disagrees
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      if (mismatch_count < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // compare every taken result with the oldest expectation
  always @(posedge clk) begin : result_check
    au_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_payload_q.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("%0t: unexpected result, payload %02h frame %0d", $time,
                   out_payload_byte, out_frame_number);
        mismatch_count++;
      end else begin
        want = expected_payload_q.pop_front();
        check_field("payload_byte", want.payload_byte, out_payload_byte);
        check_field("first_of_frame", want.first_of_frame, out_first_of_frame);
        check_field("last_of_frame", want.last_of_frame, out_last_of_frame);
        check_field("object_type", want.object_type, out_object_type);
        check_field("rate_index", want.rate_index, out_rate_index);
        check_field("sample_rate_hz", want.sample_rate_hz, out_sample_rate_hz);
        check_field("channel_config", want.channel_config, out_channel_config);
        check_field("crc_present", want.crc_present, out_crc_present);
        check_field("frame_number", want.frame_number, out_frame_number);
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin : receiver_stall
    int unsigned    hold_left;
    int unsigned    tick;
    stall_pattern_t pattern;
    logic           stall_next;
    hold_left = 0;
    tick      = 0;
    pattern   = STALL_NONE;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 64 == 0) pattern = stall_pattern_t'($urandom_range(0, 3));
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        case (pattern)
          STALL_RANDOM: stall_next = 1'($urandom);
          STALL_HEAVY:  stall_next = (tick % 4 != 0);
          STALL_SPARSE: stall_next = ($urandom_range(0, 7) == 0);
          default:      stall_next = 1'b0;
        endcase
      end
      out_stall <= stall_next;
    end
  end

  // ends the run when no request moves for too long
  initial begin : idle_watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no request taken for %0d cycles", IDLE_LIMIT);
    $display("adts_frame_deframer_tb NOT OK");
    $finish;
  end

  // test sequence
  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= '0;
    reset_predictor();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_header_fields();
    test_sync_recovery();
    test_random_stream();
    test_output_holdoff();
    test_longest_frame();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_payload_q.size() != 0)
      $display("%0d expected results never arrived", expected_payload_q.size());
    if (mismatch_count == 0 && expected_payload_q.size() == 0) begin
      $display("adts_frame_deframer_tb OK");
    end else begin
      $display("adts_frame_deframer_tb NOT OK");
    end
    $finish;
  end

endmodule
